// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks used by the front panel dial quantizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/fpdq_pkg.sv =====
// ----------------------------------------------------------------------------
// fpdq_pkg
// Types, constants and level tables of the front panel dial quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package fpdq_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRACK,
        S_COMMIT,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DIAL_RATE,
        DIAL_TIME,
        DIAL_PEEP,
        DIAL_PIP
    } t_dial;

    typedef enum logic [1:0] {
        REG_BPM_HYST,
        REG_TI_HYST,
        REG_PEEP_HYST,
        REG_PIP_HYST
    } t_reg;

    typedef enum logic [2:0] {
        OP_STANDBY = 3'd0,
        OP_CPAP    = 3'd1,
        OP_PSV     = 3'd2,
        OP_SIMV    = 3'd3,
        OP_CMV     = 3'd4
    } t_mode;

    typedef struct packed {
        logic load;
        logic shift;
        logic commit;
    } t_trk_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    typedef struct packed {
        t_mode mode;
        logic  monitor_request;
        logic  insp_hold;
        logic  apnoea_on;
        logic  soft_wave;
    } t_misc;

    localparam int LEVEL_W  = 10;
    localparam int HYST_W   = 8;
    localparam int REG_W    = 2;
    localparam int LOOKUP_W = 7;

    localparam logic [HYST_W-1:0] BPM_HYST_RST  = 8'd8;
    localparam logic [HYST_W-1:0] TI_HYST_RST   = 8'd34;
    localparam logic [HYST_W-1:0] PEEP_HYST_RST = 8'd65;
    localparam logic [HYST_W-1:0] PIP_HYST_RST  = 8'd25;

    localparam int RATE_W = 7;
    localparam int TIME_W = 5;
    localparam int PEEP_W = 4;
    localparam int PIP_W  = 6;

    localparam int RATE_LAST = 125;
    localparam int TIME_LAST = 30;
    localparam int PEEP_LAST = 15;
    localparam int PIP_LAST  = 40;

    localparam int RATE_FLOOR = 1;
    localparam int TIME_FLOOR = 2;

    // breaths per minute times ten tenths, over the rate index
    localparam int                 QUOT_W    = 13;
    localparam int                 DIV_STEPS = QUOT_W;
    localparam logic [QUOT_W-1:0] DIVIDEND  = 13'd6000;

    localparam logic [LEVEL_W-1:0] RATE_TAB [0:125] = '{
        10'd0,   10'd8,   10'd16,  10'd24,  10'd33,  10'd41,  10'd49,  10'd57,
        10'd65,  10'd73,  10'd81,  10'd90,  10'd98,  10'd106, 10'd114, 10'd122,
        10'd130, 10'd138, 10'd147, 10'd155, 10'd163, 10'd171, 10'd179, 10'd187,
        10'd195, 10'd204, 10'd212, 10'd220, 10'd228, 10'd236, 10'd244, 10'd252,
        10'd261, 10'd269, 10'd277, 10'd285, 10'd293, 10'd301, 10'd309, 10'd318,
        10'd326, 10'd334, 10'd342, 10'd350, 10'd358, 10'd366, 10'd375, 10'd383,
        10'd391, 10'd399, 10'd407, 10'd415, 10'd423, 10'd432, 10'd440, 10'd448,
        10'd456, 10'd464, 10'd472, 10'd480, 10'd489, 10'd497, 10'd505, 10'd513,
        10'd521, 10'd529, 10'd538, 10'd546, 10'd554, 10'd562, 10'd570, 10'd578,
        10'd586, 10'd595, 10'd603, 10'd611, 10'd619, 10'd627, 10'd635, 10'd643,
        10'd652, 10'd660, 10'd668, 10'd676, 10'd684, 10'd692, 10'd700, 10'd709,
        10'd717, 10'd725, 10'd733, 10'd741, 10'd749, 10'd757, 10'd766, 10'd774,
        10'd782, 10'd790, 10'd798, 10'd806, 10'd814, 10'd823, 10'd831, 10'd839,
        10'd847, 10'd855, 10'd863, 10'd871, 10'd880, 10'd888, 10'd896, 10'd904,
        10'd912, 10'd920, 10'd928, 10'd937, 10'd945, 10'd953, 10'd961, 10'd969,
        10'd977, 10'd985, 10'd994, 10'd1002, 10'd1010, 10'd1018
    };

    localparam logic [LEVEL_W-1:0] TIME_TAB [0:30] = '{
        10'd0,   10'd34,  10'd68,  10'd102, 10'd135, 10'd169, 10'd203, 10'd237,
        10'd271, 10'd305, 10'd338, 10'd372, 10'd406, 10'd440, 10'd474, 10'd508,
        10'd541, 10'd575, 10'd609, 10'd643, 10'd677, 10'd711, 10'd744, 10'd778,
        10'd812, 10'd846, 10'd880, 10'd914, 10'd947, 10'd981, 10'd1015
    };

    localparam logic [LEVEL_W-1:0] PEEP_TAB [0:15] = '{
        10'd0,   10'd81,  10'd146, 10'd212, 10'd278, 10'd343, 10'd409, 10'd475,
        10'd540, 10'd606, 10'd672, 10'd737, 10'd803, 10'd869, 10'd934, 10'd1000
    };

    localparam logic [LEVEL_W-1:0] PIP_TAB [0:40] = '{
        10'd0,   10'd35,  10'd60,  10'd85,  10'd110, 10'd135, 10'd160, 10'd185,
        10'd210, 10'd235, 10'd260, 10'd285, 10'd310, 10'd335, 10'd360, 10'd385,
        10'd410, 10'd435, 10'd460, 10'd485, 10'd510, 10'd535, 10'd560, 10'd585,
        10'd610, 10'd635, 10'd660, 10'd685, 10'd710, 10'd735, 10'd760, 10'd785,
        10'd810, 10'd835, 10'd860, 10'd885, 10'd910, 10'd935, 10'd960, 10'd985,
        10'd1010
    };

    function automatic logic [LEVEL_W-1:0] level_lookup(t_dial dial,
                                                       logic [LOOKUP_W-1:0] idx);
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        unique case (dial)
            DIAL_RATE: if (idx <= 7'd125) lvl = RATE_TAB[idx];
            DIAL_TIME: if (idx <= 7'd30)  lvl = TIME_TAB[idx[4:0]];
            DIAL_PEEP: if (idx <= 7'd15)  lvl = PEEP_TAB[idx[3:0]];
            DIAL_PIP:  if (idx <= 7'd40)  lvl = PIP_TAB[idx[5:0]];
            default:   lvl = '0;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

// ===== src/fpdq_in_if.sv =====
// ----------------------------------------------------------------------------
// fpdq_in_if
// Tick request channel: pins, buttons, switches and dial samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpdq_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [3:0]             mode_pins;
    logic                   monitor_button_n;
    logic                   hold_button_n;
    logic                   apnoea_pin;
    logic                   wave_pin;
    logic                   monitor_clear;
    logic [SAMPLE_BITS-1:0] rate_sample;
    logic [SAMPLE_BITS-1:0] time_sample;
    logic [SAMPLE_BITS-1:0] peep_sample;
    logic [SAMPLE_BITS-1:0] pip_sample;

    modport source (
        output valid, mode_pins, monitor_button_n, hold_button_n, apnoea_pin,
               wave_pin, monitor_clear, rate_sample, time_sample, peep_sample,
               pip_sample,
        input  ready
    );

    modport sink (
        input  valid, mode_pins, monitor_button_n, hold_button_n, apnoea_pin,
               wave_pin, monitor_clear, rate_sample, time_sample, peep_sample,
               pip_sample,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/fpdq_out_if.sv =====
// ----------------------------------------------------------------------------
// fpdq_out_if
// Result channel: mode, flags and dial levels of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpdq_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic       monitor_request;
    logic       insp_hold;
    logic       apnoea_on;
    logic       soft_wave;
    logic [6:0] rate_level;
    logic [4:0] time_level;
    logic [3:0] peep_level;
    logic [5:0] pip_level;
    logic       high_ie;

    modport source (
        output valid, mode, monitor_request, insp_hold, apnoea_on, soft_wave,
               rate_level, time_level, peep_level, pip_level, high_ie,
        input  ready
    );

    modport sink (
        input  valid, mode, monitor_request, insp_hold, apnoea_on, soft_wave,
               rate_level, time_level, peep_level, pip_level, high_ie,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/fpdq_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fpdq_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpdq_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/fpdq_track.sv =====
// ----------------------------------------------------------------------------
// fpdq_track
// One dial: bit-serial hysteresis compare against the table level, then a
// single step of the level index, raised to FLOOR when below it.
// ----------------------------------------------------------------------------
`default_nettype none

module fpdq_track #(
    parameter int             SAMPLE_BITS = 10,
    parameter fpdq_pkg::t_dial DIAL       = fpdq_pkg::DIAL_RATE,
    parameter int             IDX_W       = 7,
    parameter int             LAST        = 125,
    parameter int             FLOOR       = 0
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire fpdq_pkg::t_trk_ctl       i_ctl,
    input  wire logic [SAMPLE_BITS-1:0]   i_sample,
    input  wire logic [fpdq_pkg::HYST_W-1:0] i_hyst,
    output logic      [IDX_W-1:0]         o_index
);
    import fpdq_pkg::*;

    // one guard bit holds level + hysteresis and sample + hysteresis
    localparam int W     = SAMPLE_BITS + 1;
    localparam int SHIFT = SAMPLE_BITS - LEVEL_W;

    logic [W-1:0]     r_s, r_l, r_h;
    logic             r_ca, r_cb, r_gt, r_lt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [W-1:0]     lvl_ext;
    logic             sum_a, sum_b, carry_a, carry_b;
    logic [IDX_W-1:0] idx_mv;

    assign lvl_ext = W'(level_lookup(DIAL, LOOKUP_W'(r_idx))) << SHIFT;

    // a = level + hyst, b = sample + hyst, LSB first
    assign sum_a   = r_l[0] ^ r_h[0] ^ r_ca;
    assign carry_a = (r_l[0] & r_h[0]) | (r_ca & (r_l[0] ^ r_h[0]));
    assign sum_b   = r_s[0] ^ r_h[0] ^ r_cb;
    assign carry_b = (r_s[0] & r_h[0]) | (r_cb & (r_s[0] ^ r_h[0]));

    always_comb begin
        idx_mv = r_idx;
        if (r_gt && (r_idx < IDX_W'(LAST))) begin
            idx_mv = r_idx + 1'b1;
        end else if (r_lt && (r_idx != '0)) begin
            idx_mv = r_idx - 1'b1;
        end
        n_idx = idx_mv;
        if (idx_mv < IDX_W'(FLOOR)) begin
            n_idx = IDX_W'(FLOOR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s  <= W'(i_sample);
            r_l  <= lvl_ext;
            r_h  <= W'(i_hyst);
            r_ca <= 1'b0;
            r_cb <= 1'b0;
            r_gt <= 1'b0;
            r_lt <= 1'b0;
        end else if (i_ctl.shift) begin
            r_s  <= r_s >> 1;
            r_l  <= r_l >> 1;
            r_h  <= r_h >> 1;
            r_ca <= carry_a;
            r_cb <= carry_b;
            // the highest differing bit decides, so later bits overwrite
            if (r_s[0] != sum_a) begin
                r_gt <= r_s[0];
            end
            if (sum_b != r_l[0]) begin
                r_lt <= r_l[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctl.commit) begin
            r_idx <= n_idx;
        end
    end

    assign o_index = r_idx;

endmodule

`default_nettype wire

// ===== src/fpdq_div.sv =====
// ----------------------------------------------------------------------------
// fpdq_div
// Restoring divider: fixed dividend over the rate index, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpdq_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [fpdq_pkg::RATE_W-1:0]  i_divisor,
    output logic      [fpdq_pkg::QUOT_W-1:0]  o_quotient,
    output fpdq_pkg::t_div_sts                o_sts
);
    import fpdq_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [QUOT_W-1:0] r_num;
    logic [RATE_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_done;
    logic [RATE_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_num[QUOT_W-1]};
    assign fits  = (trial >= {1'b0, i_divisor});

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= DIVIDEND;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[QUOT_W-2:0], fits};
            r_rem <= fits ? RATE_W'(trial - {1'b0, i_divisor}) : RATE_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_num;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

`default_nettype wire

// ===== src/front_panel_dial_quantizer.sv =====
// ----------------------------------------------------------------------------
// front_panel_dial_quantizer
// Per-tick front panel decode: mode, buttons, switches, four hysteretic dial
// levels and the high I:E flag.
// ----------------------------------------------------------------------------
// One tick is taken at a time. The four dials are compared against their
// table levels bit-serially, one sample bit per cycle, in S_TRACK; S_COMMIT
// commits the new levels, S_START starts the divider, and the I:E test then
// runs a 13-step restoring divider on the new rate level in S_DIV, after
// which S_DONE loads the output register once it is empty or being taken.
// A new tick is accepted in the cycle after the previous result has moved
// into the output register, even if the sink has not yet taken it.
// Hysteresis registers are written through the configuration channel, which
// is always ready and should be used only while no tick is in flight. All
// levels and the monitor latch reset to zero.
`default_nettype none
`include "assert_macros.svh"

module front_panel_dial_quantizer #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpdq_in_if.sink   i_in,
    fpdq_out_if.source o_out,
    fpdq_cfg_if.sink  i_cfg
);
    import fpdq_pkg::*;

    localparam int W     = SAMPLE_BITS + 1;
    localparam int CNT_W = $clog2(W);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_mon;
    t_misc               r_misc;
    logic [HYST_W-1:0]   r_bpm_hyst, r_ti_hyst, r_peep_hyst, r_pip_hyst;

    logic                r_out_valid;
    t_misc               r_out_misc;
    logic [RATE_W-1:0]   r_out_rate;
    logic [TIME_W-1:0]   r_out_time;
    logic [PEEP_W-1:0]   r_out_peep;
    logic [PIP_W-1:0]    r_out_pip;
    logic                r_out_high;

    t_trk_ctl            trk_ctl;
    t_div_sts            div_sts;
    logic                div_start;
    logic                in_ready, in_acc, out_load;
    logic [RATE_W-1:0]   rate_idx;
    logic [TIME_W-1:0]   time_idx;
    logic [PEEP_W-1:0]   peep_idx;
    logic [PIP_W-1:0]    pip_idx;
    logic [QUOT_W-1:0]   quotient;
    logic [8:0]          ti_x15;
    logic                high_ie;
    t_mode               mode_dec;
    logic                n_mon;

    // ---- configuration ----
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpm_hyst  <= BPM_HYST_RST;
            r_ti_hyst   <= TI_HYST_RST;
            r_peep_hyst <= PEEP_HYST_RST;
            r_pip_hyst  <= PIP_HYST_RST;
        end else if (i_cfg.valid) begin
            unique case (t_reg'(i_cfg.index))
                REG_BPM_HYST:  r_bpm_hyst  <= i_cfg.data;
                REG_TI_HYST:   r_ti_hyst   <= i_cfg.data;
                REG_PEEP_HYST: r_peep_hyst <= i_cfg.data;
                REG_PIP_HYST:  r_pip_hyst  <= i_cfg.data;
                default:       r_pip_hyst  <= r_pip_hyst;
            endcase
        end
    end

    // ---- request decode ----
    assign in_acc = i_in.valid & in_ready;
    assign i_in.ready = in_ready;

    always_comb begin
        priority if (!i_in.mode_pins[0]) mode_dec = OP_CPAP;
        else if (!i_in.mode_pins[1])     mode_dec = OP_PSV;
        else if (!i_in.mode_pins[2])     mode_dec = OP_SIMV;
        else if (!i_in.mode_pins[3])     mode_dec = OP_CMV;
        else                             mode_dec = OP_STANDBY;
    end

    // clear first, then a press sets the latch
    assign n_mon = (r_mon & ~i_in.monitor_clear) | ~i_in.monitor_button_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mon <= 1'b0;
        end else if (in_acc) begin
            r_mon <= n_mon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_misc.mode            <= mode_dec;
            r_misc.monitor_request <= n_mon;
            r_misc.insp_hold       <= ~i_in.hold_button_n;
            r_misc.apnoea_on       <= i_in.apnoea_pin;
            r_misc.soft_wave       <= i_in.wave_pin;
        end
    end

    // ---- dials ----
    fpdq_track #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIAL        (DIAL_RATE),
        .IDX_W       (RATE_W),
        .LAST        (RATE_LAST),
        .FLOOR       (RATE_FLOOR)
    ) u_rate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (trk_ctl),
        .i_sample (i_in.rate_sample),
        .i_hyst   (r_bpm_hyst),
        .o_index  (rate_idx)
    );

    fpdq_track #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIAL        (DIAL_TIME),
        .IDX_W       (TIME_W),
        .LAST        (TIME_LAST),
        .FLOOR       (TIME_FLOOR)
    ) u_time (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (trk_ctl),
        .i_sample (i_in.time_sample),
        .i_hyst   (r_ti_hyst),
        .o_index  (time_idx)
    );

    fpdq_track #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIAL        (DIAL_PEEP),
        .IDX_W       (PEEP_W),
        .LAST        (PEEP_LAST),
        .FLOOR       (0)
    ) u_peep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (trk_ctl),
        .i_sample (i_in.peep_sample),
        .i_hyst   (r_peep_hyst),
        .o_index  (peep_idx)
    );

    fpdq_track #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIAL        (DIAL_PIP),
        .IDX_W       (PIP_W),
        .LAST        (PIP_LAST),
        .FLOOR       (0)
    ) u_pip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (trk_ctl),
        .i_sample (i_in.pip_sample),
        .i_hyst   (r_pip_hyst),
        .o_index  (pip_idx)
    );

    // ---- I:E test: 6000 / rate - 10 * ti < 5 * ti, i.e. quotient < 15 * ti ----
    fpdq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (rate_idx),
        .o_quotient (quotient),
        .o_sts      (div_sts)
    );

    assign ti_x15  = {time_idx, 4'b0000} - {4'b0000, time_idx};
    assign high_ie = (quotient < {4'b0000, ti_x15});

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_TRACK;
            S_TRACK:  if (r_cnt == CNT_W'(W - 1)) n_state = S_COMMIT;
            S_COMMIT: n_state = S_START;
            S_START:  n_state = S_DIV;
            S_DIV:    if (div_sts.done) n_state = S_DONE;
            S_DONE:   if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready       = 1'b0;
        trk_ctl.load   = 1'b0;
        trk_ctl.shift  = 1'b0;
        trk_ctl.commit = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready     = 1'b1;
                trk_ctl.load = i_in.valid;
            end
            S_TRACK:  trk_ctl.shift  = 1'b1;
            S_COMMIT: trk_ctl.commit = 1'b1;
            S_START:  div_start      = 1'b1;
            S_DIV:    out_load       = 1'b0;
            S_DONE:   out_load       = !r_out_valid || o_out.ready;
            default:  out_load       = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_TRACK) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_misc <= r_misc;
            r_out_rate <= rate_idx;
            r_out_time <= time_idx;
            r_out_peep <= peep_idx;
            r_out_pip  <= pip_idx;
            r_out_high <= high_ie;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.mode            = r_out_misc.mode;
    assign o_out.monitor_request = r_out_misc.monitor_request;
    assign o_out.insp_hold       = r_out_misc.insp_hold;
    assign o_out.apnoea_on       = r_out_misc.apnoea_on;
    assign o_out.soft_wave       = r_out_misc.soft_wave;
    assign o_out.rate_level      = r_out_rate;
    assign o_out.time_level      = r_out_time;
    assign o_out.peep_level      = r_out_peep;
    assign o_out.pip_level       = r_out_pip;
    assign o_out.high_ie         = r_out_high;

    // ---- checks ----
    `ASSERT_NXT(a_accept_starts_track, i_clk, i_rst_n, in_acc, r_state == S_TRACK)
    `ASSERT_IMP(a_result_floors, i_clk, i_rst_n, r_out_valid, (r_out_rate != '0) && (r_out_time > 5'd1))
    `ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_sts.done, r_state == S_DIV)
    `ASSERT_IMP(a_div_busy_in_div, i_clk, i_rst_n, div_sts.busy, r_state == S_DIV)

endmodule

`default_nettype wire
